@@ rtl/card_number_luhn_checker_assert.svh @@
// Assertion macros for the card number checker RTL.
`ifndef CARD_NUMBER_LUHN_CHECKER_ASSERT_SVH
`define CARD_NUMBER_LUHN_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CLC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("card number checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("card number checker: next-cycle check failed");

`endif

@@ rtl/clc_pkg.sv @@
// Types, codes and digit arithmetic helpers for the card number checker.
package clc_pkg;

    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 5;
    localparam int SUM_W   = 4;
    localparam int LEN_W   = 5;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 5'd13;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 5'd16;

    localparam logic [IDX_W-1:0] REG_MIN_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_PFX  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SUM  = 2'd3;

    localparam logic [DIGIT_W-1:0] DIG_THREE = 4'd3;
    localparam logic [DIGIT_W-1:0] DIG_FOUR  = 4'd4;
    localparam logic [DIGIT_W-1:0] DIG_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] DIG_SIX   = 4'd6;
    localparam logic [DIGIT_W-1:0] DIG_SEVEN = 4'd7;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [DIGIT_W-1:0] first;
        logic [DIGIT_W-1:0] second;
        logic [SUM_W-1:0]   sum_even;
        logic [SUM_W-1:0]   sum_odd;
    } number_state_t;

    typedef struct packed {
        logic              valid_res;
        logic [STAT_W-1:0] status;
    } result_t;

    // Sum of the decimal digits of twice the digit, which equals t - 9 * (t / 10).
    function automatic logic [4:0] doubled_value(input logic [DIGIT_W-1:0] d);
        logic [4:0] t;
        logic [4:0] r;
        t = {d, 1'b0};
        if (t >= 5'd30) begin
            r = t - 5'd27;
        end else if (t >= 5'd20) begin
            r = t - 5'd18;
        end else if (t >= 5'd10) begin
            r = t - 5'd9;
        end else begin
            r = t;
        end
        return r;
    endfunction

    // Adds a term of at most fifteen to a residue and reduces modulo ten.
    function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] s,
                                                   input logic [4:0] v);
        logic [4:0] t;
        logic [4:0] r;
        t = {1'b0, s} + v;
        if (t >= 5'd20) begin
            r = t - 5'd20;
        end else if (t >= 5'd10) begin
            r = t - 5'd10;
        end else begin
            r = t;
        end
        return r[SUM_W-1:0];
    endfunction

endpackage

@@ rtl/clc_accum.sv @@
// Per-number running state: digit count, leading digits and both Luhn sums.
module clc_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [clc_pkg::DIGIT_W-1:0]   digit,
    input  logic                          last,
    output clc_pkg::number_state_t        cur_state,
    output clc_pkg::number_state_t        upd_state
);

    clc_pkg::number_state_t state_reg;
    clc_pkg::number_state_t state_next;
    logic [4:0]             dbl;
    logic [4:0]             plain;

    assign dbl   = clc_pkg::doubled_value(digit);
    assign plain = {1'b0, digit};

    always_comb begin
        upd_state = state_reg;
        if (state_reg.count == '0) begin
            upd_state.first  = digit;
            upd_state.second = '0;
        end else if (state_reg.count == 5'd1) begin
            upd_state.second = digit;
        end
        if (!state_reg.count[0]) begin
            upd_state.sum_even = clc_pkg::add_mod10(state_reg.sum_even, dbl);
            upd_state.sum_odd  = clc_pkg::add_mod10(state_reg.sum_odd, plain);
        end else begin
            upd_state.sum_even = clc_pkg::add_mod10(state_reg.sum_even, plain);
            upd_state.sum_odd  = clc_pkg::add_mod10(state_reg.sum_odd, dbl);
        end
        if (state_reg.count != clc_pkg::COUNT_MAX) begin
            upd_state.count = state_reg.count + 5'd1;
        end
    end

    always_comb begin
        state_next = state_reg;
        if (advance) begin
            state_next = last ? '0 : upd_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cur_state = state_reg;

endmodule

@@ rtl/clc_verdict.sv @@
// Final length, prefix and checksum tests with the result register.
module clc_verdict (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  clc_pkg::number_state_t        upd_state,
    input  logic [clc_pkg::LEN_W-1:0]     min_len,
    input  logic [clc_pkg::LEN_W-1:0]     max_len,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output clc_pkg::result_t              result
);

    logic                          out_valid_reg;
    logic                          out_valid_next;
    clc_pkg::result_t              res_reg;
    clc_pkg::result_t              res_next;
    logic                          bad_len;
    logic                          pfx_ok;
    logic [clc_pkg::SUM_W-1:0]     sel_sum;

    assign bad_len = (upd_state.count < min_len) || (upd_state.count > max_len);
    assign pfx_ok  = (upd_state.first == clc_pkg::DIG_FOUR) ||
                     (upd_state.first == clc_pkg::DIG_FIVE) ||
                     (upd_state.first == clc_pkg::DIG_SIX)  ||
                     ((upd_state.first == clc_pkg::DIG_THREE) &&
                      (upd_state.second == clc_pkg::DIG_SEVEN));
    assign sel_sum = upd_state.count[0] ? upd_state.sum_odd : upd_state.sum_even;

    always_comb begin
        if (bad_len) begin
            res_next.status = clc_pkg::ST_BAD_LEN;
        end else if (!pfx_ok) begin
            res_next.status = clc_pkg::ST_BAD_PFX;
        end else if (sel_sum != '0) begin
            res_next.status = clc_pkg::ST_BAD_SUM;
        end else begin
            res_next.status = clc_pkg::ST_OK;
        end
        res_next.valid_res = (res_next.status == clc_pkg::ST_OK);
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = res_reg;

endmodule

@@ rtl/card_number_luhn_checker.sv @@
// Top level of the streaming Luhn card number checker.
// The block takes one decimal digit per request, most significant first, at a sustained rate
// of one digit per clock cycle; tlast marks the final digit. Each digit is held in an input
// register and then folded into the running count, leading digits and the two Luhn sums. The
// request that carries tlast produces one result, which reaches the master side through the
// input and result registers: tdata bit 0 is the pass flag and bits 2:1 the status (0 pass,
// 1 bad length, 2 bad prefix, 3 bad checksum, first failure wins). Only a final digit whose
// result register is still occupied stalls the input. The length bounds are written on the
// configuration channel (index 0 minimum, index 1 maximum, other indexes ignored), reset to
// 13 and 16; the user must write them only while no number is in progress (not enforced).
`include "card_number_luhn_checker_assert.svh"

module card_number_luhn_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] valid_res, [2:1] status, [7:3] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [clc_pkg::IDX_W-1:0] cfg_index,
    input  logic [clc_pkg::LEN_W-1:0] cfg_data
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [clc_pkg::DIGIT_W-1:0]   in_digit_reg;
    logic                          in_last_reg;
    logic                          out_free;
    logic                          adv;
    logic                          in_take;
    logic [clc_pkg::LEN_W-1:0]     min_len_reg;
    logic [clc_pkg::LEN_W-1:0]     max_len_reg;
    clc_pkg::number_state_t        cur_state;
    clc_pkg::number_state_t        upd_state;
    clc_pkg::result_t              result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= clc_pkg::MIN_LEN_RESET;
            max_len_reg <= clc_pkg::MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == clc_pkg::REG_MIN_LENGTH) begin
                min_len_reg <= cfg_data;
            end else if (cfg_index == clc_pkg::REG_MAX_LENGTH) begin
                max_len_reg <= cfg_data;
            end
        end
    end

    assign out_free = !m_tvalid || m_tready;
    assign adv      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || adv;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg && !adv;
        if (in_take) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_digit_reg <= s_tdata[clc_pkg::DIGIT_W-1:0];
            in_last_reg  <= s_tlast;
        end
    end

    clc_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (adv),
        .digit     (in_digit_reg),
        .last      (in_last_reg),
        .cur_state (cur_state),
        .upd_state (upd_state)
    );

    clc_verdict u_verdict (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (adv && in_last_reg),
        .upd_state (upd_state),
        .min_len   (min_len_reg),
        .max_len   (max_len_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .result    (result)
    );

    assign m_tdata = {5'd0, result.status, result.valid_res};

    // A finished number leaves the running state cleared for the next one.
    `CLC_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, adv && in_last_reg, cur_state.count == '0)
    // A digit that is not the last never produces a result.
    `CLC_ASSERT_NEXT(a_no_spurious_res, aclk, aresetn, adv && !in_last_reg,
                     m_tvalid == $past(m_tvalid && !m_tready))
    // The input only stalls behind a final digit waiting for the result register.
    `CLC_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, in_valid_reg && in_last_reg && !out_free)
    // The pass flag agrees with the status code.
    `CLC_ASSERT_IMP(a_flag_matches, aclk, aresetn, m_tvalid,
                    result.valid_res == (result.status == clc_pkg::ST_OK))

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the streaming Luhn card number checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES   = 800;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_DIGITS  = 155;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_NUM_LEN   = 40;
    localparam logic [clc_pkg::IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [clc_pkg::IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct {
        logic [clc_pkg::DIGIT_W-1:0] digit;
        logic                        lst;
        bit                          typed;
        clc_pkg::result_t            res;
    } dir_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata = '0;
    logic                       s_tlast = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [7:0]                 m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [clc_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [clc_pkg::LEN_W-1:0]  cfg_data = '0;

    // Predicted block state and register copies.
    logic [clc_pkg::LEN_W-1:0]   min_len_q;
    logic [clc_pkg::LEN_W-1:0]   max_len_q;
    logic [clc_pkg::COUNT_W-1:0] count_q;
    logic [clc_pkg::DIGIT_W-1:0] first_q;
    logic [clc_pkg::DIGIT_W-1:0] second_q;
    logic [clc_pkg::SUM_W-1:0]   sum_even_q;
    logic [clc_pkg::SUM_W-1:0]   sum_odd_q;

    clc_pkg::result_t verdict_q[$];
    int               err_cnt = 0;
    int               digits_sent = 0;
    int               stall_cnt = 0;
    bit               tx_burst = 1'b0;
    bit               rx_burst = 1'b0;
    bit               hold_req = 1'b0;
    dir_row_t         dir_rows[21];

    card_number_luhn_checker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int luhn_double(input logic [clc_pkg::DIGIT_W-1:0] d);
        int t;
        t = 2 * int'(d);
        return t / 10 + t % 10;
    endfunction

    function automatic void clear_number();
        count_q    = '0;
        first_q    = '0;
        second_q   = '0;
        sum_even_q = '0;
        sum_odd_q  = '0;
    endfunction

    // Folds one digit into the predicted state; returns 1 with the verdict on a final digit.
    function automatic bit luhn_step(input logic [clc_pkg::DIGIT_W-1:0] d, input logic lst,
                                     output clc_pkg::result_t r);
        int                        pos;
        int                        len;
        logic [clc_pkg::SUM_W-1:0] sel;
        r   = '0;
        pos = int'(count_q);
        if (pos == 0) begin
            first_q  = d;
            second_q = '0;
        end else if (pos == 1) begin
            second_q = d;
        end
        if (pos % 2 == 0) begin
            sum_even_q = clc_pkg::SUM_W'((int'(sum_even_q) + luhn_double(d)) % 10);
            sum_odd_q  = clc_pkg::SUM_W'((int'(sum_odd_q) + int'(d)) % 10);
        end else begin
            sum_even_q = clc_pkg::SUM_W'((int'(sum_even_q) + int'(d)) % 10);
            sum_odd_q  = clc_pkg::SUM_W'((int'(sum_odd_q) + luhn_double(d)) % 10);
        end
        count_q = (count_q < clc_pkg::COUNT_MAX) ? count_q + 1'b1 : clc_pkg::COUNT_MAX;
        if (!lst) begin
            return 1'b0;
        end
        len = int'(count_q);
        sel = (len % 2 == 1) ? sum_odd_q : sum_even_q;
        if (len < int'(min_len_q) || len > int'(max_len_q)) begin
            r.status = clc_pkg::ST_BAD_LEN;
        end else if (!(first_q == clc_pkg::DIG_FOUR || first_q == clc_pkg::DIG_FIVE ||
                       first_q == clc_pkg::DIG_SIX ||
                       (first_q == clc_pkg::DIG_THREE && second_q == clc_pkg::DIG_SEVEN)))
        begin
            r.status = clc_pkg::ST_BAD_PFX;
        end else if (sel != '0) begin
            r.status = clc_pkg::ST_BAD_SUM;
        end else begin
            r.status = clc_pkg::ST_OK;
        end
        r.valid_res = (r.status == clc_pkg::ST_OK);
        clear_number();
        return 1'b1;
    endfunction

    task automatic send_digit(input logic [clc_pkg::DIGIT_W-1:0] d, input logic lst,
                              input bit use_typed, input clc_pkg::result_t typed_res);
        int               gap;
        clc_pkg::result_t r;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, d};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        digits_sent++;
        if (luhn_step(d, lst, r)) begin
            verdict_q.push_back(use_typed ? typed_res : r);
        end
    endtask

    task automatic write_reg(input logic [clc_pkg::IDX_W-1:0] idx,
                             input logic [clc_pkg::LEN_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == clc_pkg::REG_MIN_LENGTH) begin
            min_len_q = val;
        end else if (idx == clc_pkg::REG_MAX_LENGTH) begin
            max_len_q = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sender stops offering requests until every verdict is back and the pipeline is empty.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_number(input int lo, input int hi);
        logic [clc_pkg::DIGIT_W-1:0] num[MAX_NUM_LEN];
        int                          n;
        int                          acc;
        int                          mode;
        if (lo < 1) lo = 1;
        if (hi > 31) hi = 31;
        mode = $urandom_range(0, 9);
        if (lo > hi || mode == 0) begin
            n = $urandom_range(1, MAX_NUM_LEN);
        end else if (mode == 1) begin
            n = ($urandom_range(0, 1) != 0) ? hi + 1 : ((lo > 1) ? lo - 1 : 1);
        end else if (mode == 2) begin
            n = ($urandom_range(0, 1) != 0) ? hi : lo;
        end else begin
            n = $urandom_range(lo, hi);
        end
        for (int p = 0; p < MAX_NUM_LEN; p++) begin
            num[p] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 9));
        end
        mode = $urandom_range(0, 7);
        if (mode <= 2) begin
            num[0] = 4'($urandom_range(clc_pkg::DIG_FOUR, clc_pkg::DIG_SIX));
        end else if (mode <= 4) begin
            num[0] = clc_pkg::DIG_THREE;
            num[1] = clc_pkg::DIG_SEVEN;
        end else if (mode == 5) begin
            num[0] = clc_pkg::DIG_THREE;
        end
        // Most well-formed numbers also get a check digit that makes the sum pass.
        if (n >= 3 && n <= 31 && $urandom_range(0, 3) != 0) begin
            acc = 0;
            for (int p = 0; p < n - 1; p++) begin
                acc += ((p % 2) != ((n - 1) % 2)) ? luhn_double(num[p]) : int'(num[p]);
            end
            num[n-1] = 4'((10 - acc % 10) % 10);
        end
        if ($urandom_range(0, 7) == 0) tx_burst = ~tx_burst;
        for (int p = 0; p < n; p++) begin
            send_digit(num[p], p == n - 1, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, bursts, and one long hold-off on request.
    initial begin
        int               stall;
        clc_pkg::result_t e;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 7) == 0) rx_burst = ~rx_burst;
            stall = hold_req ? HOLD_CYCLES : (rx_burst ? 0 : $urandom_range(0, 15));
            hold_req = 1'b0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, got valid_res=%0b status=%0d",
                         $time, m_tdata[0], m_tdata[2:1]);
                err_cnt++;
            end else begin
                e = verdict_q.pop_front();
                if (m_tdata[0] !== e.valid_res) begin
                    $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                             $time, e.valid_res, m_tdata[0]);
                    err_cnt++;
                end
                if (m_tdata[2:1] !== e.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, e.status, m_tdata[2:1]);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt == STALL_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [clc_pkg::LEN_W-1:0] bounds[NUM_PHASES][2];
        clc_pkg::result_t          bad_len;
        clc_pkg::result_t          ok;
        bad_len = '{valid_res: 1'b0, status: clc_pkg::ST_BAD_LEN};
        ok      = '{valid_res: 1'b1, status: clc_pkg::ST_OK};
        // A lone digit, then a known good sixteen-digit number, then digits up to fifteen.
        dir_rows = '{
            '{4'd4, 1'b1, 1'b1, bad_len},
            '{4'd4, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0},
            '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0},
            '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0},
            '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0},
            '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0}, '{4'd1, 1'b0, 1'b0, '0},
            '{4'd1, 1'b1, 1'b1, ok},
            '{4'd15, 1'b0, 1'b0, '0}, '{4'd9, 1'b0, 1'b0, '0}, '{4'd0, 1'b0, 1'b0, '0},
            '{4'd8, 1'b1, 1'b0, '0}
        };
        bounds = '{'{5'd2, 5'd30}, '{5'd13, 5'd16}, '{5'd2, 5'd2}, '{5'd30, 5'd30},
                   '{5'd20, 5'd10}, '{5'd0, 5'd31}, '{5'd31, 5'd0}, '{5'd1, 5'd8}};
        min_len_q = clc_pkg::MIN_LEN_RESET;
        max_len_q = clc_pkg::MAX_LEN_RESET;
        clear_number();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_digit(dir_rows[i].digit, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].res);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(REG_SPARE_LO, clc_pkg::LEN_W'($urandom));
            write_reg(clc_pkg::REG_MIN_LENGTH, bounds[ph][0]);
            write_reg(clc_pkg::REG_MAX_LENGTH, bounds[ph][1]);
            write_reg(REG_SPARE_HI, clc_pkg::LEN_W'($urandom));
            // The first phase accepts lengths from 2 to 30, and the long hold-off backs up the input.
            if (ph == 0) hold_req = 1'b1;
            digits_sent = 0;
            while (digits_sent < PHASE_DIGITS) begin
                send_number(int'(min_len_q), int'(max_len_q));
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/clc_pkg.sv
rtl/clc_accum.sv
rtl/clc_verdict.sv
rtl/card_number_luhn_checker.sv
dv/tb_top.sv
